FILE: rtl/mft_pkg.sv
// Package with the constants, command codes and entry type of the MAC forwarding table.
package mft_pkg;
	localparam int TableEntries = 1024;
	localparam int PortBits = 8;
	localparam int IdxW = $clog2(TableEntries);
	localparam int CntW = IdxW + 1;

	typedef enum logic [3:0] {
		CMD_LEARN     = 4'd0,
		CMD_STATIC    = 4'd1,
		CMD_LOOKUP    = 4'd2,
		CMD_TICK      = 4'd3,
		CMD_AGE       = 4'd4,
		CMD_FLUSH_P   = 4'd5,
		CMD_FLUSH_V   = 4'd6,
		CMD_FLUSH_DYN = 4'd7,
		CMD_FLUSH_ALL = 4'd8
	} cmd_t;

	// One stored entry, its valid bit included.
	typedef struct packed {
		logic                valid;
		logic [59:0]         key;
		logic [PortBits-1:0] port;
		logic                pinned;
		logic [31:0]         seen_at;
	} entry_t;
endpackage

FILE: rtl/mac_forwarding_table_with_aging.sv
// Top level of the MAC forwarding table with ageing: sequencer, entry memory and sweep logic.
//
//  Channel  | Signals                                    | Handshake
//  ---------+--------------------------------------------+------------------
//  in       | cmd, mac_address, vlan, port               | in_valid/in_ready
//  out      | found, hit_port, status, table_count       | out_valid/out_ready
//  config   | aging_timeout_wdata                        | aging_timeout_we
//
// After reset the block clears every slot, one per cycle, and takes no word until the last
// slot is cleared; the counters and the timeout (300) reset at once, the valid bits by the clear.
// Tick and unknown commands offer their result in the cycle after acceptance.
// Flush all clears the slots one per cycle and offers its result once the last slot is cleared.
// Every other command sweeps all slots through the single registered read port, then passes
// through DRAIN and WRITE before it offers its result; the next word is taken only after the
// result is taken. A held result keeps in_ready low.
module mac_forwarding_table_with_aging
	import mft_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                aging_timeout_we,
	input  logic [19:0]         aging_timeout_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [3:0]          cmd,
	input  logic [47:0]         mac_address,
	input  logic [11:0]         vlan,
	input  logic [7:0]          port,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                found,
	output logic [7:0]          hit_port,
	output logic                status,
	output logic [10:0]         table_count
);
	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_SCAN  = 6'b000100,
		ST_DRAIN = 6'b001000,
		ST_WRITE = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t state_q;
	logic init_q;
	logic [19:0] timeout_q;
	logic [31:0] now_q;
	logic [CntW-1:0] count_q;
	entry_t mem [TableEntries];

	logic [3:0] cmd_q;
	logic [59:0] key_q;
	logic [PortBits-1:0] port_q;
	logic [11:0] vlan_q;

	logic [IdxW-1:0] rd_idx_q;
	logic rd_vld_s1;
	logic [IdxW-1:0] rd_idx_s1;
	entry_t rd_s1;

	logic hit_q, free_q, hit_pin_q;
	logic [IdxW-1:0] hit_idx_q, free_idx_q;
	logic found_q, status_q;
	logic [PortBits-1:0] hit_port_q;

	logic accept;
	logic last_slot;
	logic slot_valid;
	logic key_match;
	logic drop;
	logic [31:0] elapsed;
	logic wr_en;
	logic [IdxW-1:0] wr_idx;
	entry_t wr_data;

	assign accept      = in_valid && in_ready;
	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = (state_q == ST_OUT);
	assign found       = found_q;
	assign hit_port    = hit_port_q;
	assign status      = status_q;
	assign table_count = count_q;
	assign last_slot   = (rd_idx_q == IdxW'(TableEntries - 1));

	// Judge the slot whose data has just come out of the memory.
	assign slot_valid = rd_vld_s1 && rd_s1.valid;
	assign key_match  = slot_valid && (rd_s1.key == key_q);
	assign elapsed    = now_q - rd_s1.seen_at;
	always_comb begin
		drop = 1'b0;
		if (slot_valid && !rd_s1.pinned) begin
			unique case (cmd_q)
				CMD_AGE:       drop = (elapsed >= {12'd0, timeout_q});
				CMD_FLUSH_P:   drop = (rd_s1.port == port_q);
				CMD_FLUSH_V:   drop = (rd_s1.key[11:0] == vlan_q);
				CMD_FLUSH_DYN: drop = 1'b1;
				default:       drop = 1'b0;
			endcase
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 20'd300;
		end else if (aging_timeout_we) begin
			timeout_q <= aging_timeout_wdata;
		end
	end

	// The single write port: clearing, dropping during a sweep, or the final update.
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = rd_idx_q;
		wr_data = '0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
			end
			ST_SCAN, ST_DRAIN: begin
				wr_en  = drop;
				wr_idx = rd_idx_s1;
			end
			ST_WRITE: begin
				if ((cmd_q == CMD_LEARN || cmd_q == CMD_STATIC) && (hit_q || free_q)) begin
					wr_en   = 1'b1;
					wr_idx  = hit_q ? hit_idx_q : free_idx_q;
					wr_data = '{valid: 1'b1, key: key_q, port: port_q,
						pinned: (cmd_q == CMD_STATIC), seen_at: now_q};
				end else if (cmd_q == CMD_LOOKUP && hit_q && !hit_pin_q) begin
					wr_en   = 1'b1;
					wr_idx  = hit_idx_q;
					wr_data = '{valid: 1'b1, key: key_q, port: hit_port_q,
						pinned: 1'b0, seen_at: now_q};
				end
			end
			default: begin
			end
		endcase
	end

	// Entry memory: one registered read and one write per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		rd_s1 <= mem[rd_idx_q];
	end

	// Command payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd;
			key_q  <= {mac_address, vlan};
			port_q <= port[PortBits-1:0];
			vlan_q <= vlan;
		end
	end

	// Sequencer, sweep and table bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			init_q     <= 1'b1;
			now_q      <= '0;
			count_q    <= '0;
			rd_idx_q   <= '0;
			rd_vld_s1  <= 1'b0;
			rd_idx_s1  <= '0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			hit_pin_q  <= 1'b0;
			hit_idx_q  <= '0;
			free_idx_q <= '0;
			found_q    <= 1'b0;
			hit_port_q <= '0;
			status_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			rd_idx_s1 <= rd_idx_q;
			unique case (state_q)
				ST_CLEAR: begin
					rd_idx_q <= rd_idx_q + IdxW'(1);
					if (last_slot) begin
						init_q  <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_OUT;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						rd_idx_q   <= '0;
						hit_q      <= 1'b0;
						free_q     <= 1'b0;
						hit_pin_q  <= 1'b0;
						found_q    <= 1'b0;
						hit_port_q <= '0;
						status_q   <= 1'b0;
						unique case (cmd)
							CMD_TICK: begin
								now_q   <= now_q + 32'd1;
								state_q <= ST_OUT;
							end
							CMD_FLUSH_ALL: begin
								count_q <= '0;
								state_q <= ST_CLEAR;
							end
							CMD_LEARN, CMD_STATIC, CMD_LOOKUP, CMD_AGE,
							CMD_FLUSH_P, CMD_FLUSH_V, CMD_FLUSH_DYN: begin
								state_q <= ST_SCAN;
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_SCAN, ST_DRAIN: begin
					if (state_q == ST_SCAN) begin
						rd_idx_q <= rd_idx_q + IdxW'(1);
						if (last_slot) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						state_q <= ST_WRITE;
					end
					// Keep what a hit needs so that no second read is required.
					if (key_match) begin
						hit_q     <= 1'b1;
						hit_idx_q <= rd_idx_s1;
						hit_pin_q <= rd_s1.pinned;
						if (cmd_q == CMD_LOOKUP) begin
							found_q    <= 1'b1;
							hit_port_q <= rd_s1.port;
						end
					end
					// The lowest free slot is the first invalid one seen.
					if (rd_vld_s1 && !rd_s1.valid && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= rd_idx_s1;
					end
					if (drop) begin
						count_q <= count_q - CntW'(1);
					end
				end
				ST_WRITE: begin
					state_q <= ST_OUT;
					if (cmd_q == CMD_LEARN || cmd_q == CMD_STATIC) begin
						if (!hit_q && !free_q) begin
							status_q <= 1'b1;
						end else if (!hit_q) begin
							count_q <= count_q + CntW'(1);
						end
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Checks on the sequencer and the counters.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register is not one-hot");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !out_ready) |=>
		(state_q == ST_OUT && $stable({found_q, hit_port_q, status_q, count_q})))
		else $error("result dropped or changed before it was taken");
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second word taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(TableEntries))
		else $error("entry count above the table size");
endmodule
